// ===== rtl/delay_line_void_filling_scheduler_top_assert.svh =====
// Assertion macros used by the scheduler checker.
`ifndef DELAY_LINE_VOID_FILLING_SCHEDULER_TOP_ASSERT_SVH
`define DELAY_LINE_VOID_FILLING_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLVFS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define DLVFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

// ===== rtl/dlvfs_pkg.sv =====
// Package for the delay line void filling scheduler: defaults, codes and states.
package dlvfs_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam int TIME_BITS_DEF    = 32;
   localparam int CHANNEL_BITS     = 3;
   localparam int FIELD_TIME_BITS  = 32;

   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_SAVE     = 2'd1,
      CMD_RESTORE  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_COPY
   } state_type;

endpackage

// ===== rtl/dlvfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dlvfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/delay_line_void_filling_scheduler_top.sv =====
// Delay line channel scheduler with void filling and a snapshot table.
// Input channel (req_): command, request_time, duration. Accepted when
// req_valid is high and req_stall is low. Commands: schedule, save, restore;
// the unused code is accepted and dropped.
// Result channel (rsp_): found, channel, start_time, one item per schedule
// command, none for save or restore. Taken when rsp_valid is high and
// rsp_stall is low.
// Sequence: a schedule command scans the channel table one entry per cycle
// through the working table RAM read port; save and restore sweep the table
// the same way. req_stall is high from accept until the block is back in
// idle, so one item runs at a time: a new item is not taken before the last
// one is through.
// A finished result waits in the output register; a stalled receiver holds
// the block in its write step until the register frees, and the next item
// is taken while the last result still waits.
// Reset (synchronous, active high) empties the working and snapshot tables
// at once through per-entry valid bits; no clearing pass is needed.
module delay_line_void_filling_scheduler_top
   import dlvfs_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int TIME_BITS    = TIME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   input  logic [FIELD_TIME_BITS-1:0] req_request_time,
   input  logic [FIELD_TIME_BITS-1:0] req_duration,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [CHANNEL_BITS-1:0]    rsp_channel,
   output logic [FIELD_TIME_BITS-1:0] rsp_start_time
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam int ENT_W = 3 * TIME_BITS;

   typedef struct packed {
      logic [TIME_BITS-1:0] hor;
      logic [TIME_BITS-1:0] vstart;
      logic [TIME_BITS-1:0] vend;
   } entry_type;

   // sequencer
   state_type            state_ff, state_in;
   logic                 save_ff, save_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ev_pend_ff, ev_pend_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic                 rd_vld_ff, rd_vld_in;

   // request and best candidate
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [TIME_BITS-1:0] dur_ff, dur_in;
   logic [TIME_BITS-1:0] sum_ff, sum_in;
   logic                 have_ff, have_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0] best_gap_ff, best_gap_in;
   entry_type            best_ent_ff, best_ent_in;

   // valid bits of both tables
   logic [NUM_CHANNELS-1:0] work_vld_ff, work_vld_in;
   logic [NUM_CHANNELS-1:0] snap_vld_ff, snap_vld_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [CHANNEL_BITS-1:0]    rsp_channel_ff, rsp_channel_in;
   logic [FIELD_TIME_BITS-1:0] rsp_start_ff, rsp_start_in;

   // RAM ports
   logic             work_wr_en, snap_wr_en, work_rd_en, snap_rd_en;
   logic [IDX_W-1:0] work_wr_addr, rd_addr;
   entry_type        work_wr_data;
   logic [ENT_W-1:0] work_rd_raw, snap_rd_raw;

   // control and datapath
   logic                 accept;
   logic                 issue;
   logic                 sweep_done;
   logic                 leave_write;
   logic [TIME_BITS:0]   sum_full;
   entry_type            ent;
   entry_type            upd;
   logic                 void_ok, hor_ok, pick_void, cand_ok, take;
   logic [TIME_BITS-1:0] gap_v, gap_h, cand_gap, room;

   dlvfs_ram #(.WIDTH(ENT_W), .DEPTH(NUM_CHANNELS)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_wr_en),
      .wr_addr (work_wr_addr),
      .wr_data (work_wr_data),
      .rd_en   (work_rd_en),
      .rd_addr (rd_addr),
      .rd_data (work_rd_raw)
   );

   dlvfs_ram #(.WIDTH(ENT_W), .DEPTH(NUM_CHANNELS)) u_snap_ram (
      .clock   (clock),
      .wr_en   (snap_wr_en),
      .wr_addr (ev_idx_ff),
      .wr_data (ent),
      .rd_en   (snap_rd_en),
      .rd_addr (rd_addr),
      .rd_data (snap_rd_raw)
   );

   assign accept      = (state_ff == ST_IDLE) && req_valid;
   assign issue       = ((state_ff == ST_SCAN) || (state_ff == ST_COPY)) &&
                        (cnt_ff < CNT_W'(NUM_CHANNELS));
   assign sweep_done  = (cnt_ff == CNT_W'(NUM_CHANNELS)) && !ev_pend_ff;
   assign leave_write = (state_ff == ST_WRITE) && (!rsp_valid_ff || !rsp_stall);
   assign rd_addr     = cnt_ff[IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_SCHEDULE:          state_in = ST_SCAN;
                  CMD_SAVE, CMD_RESTORE: state_in = ST_COPY;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (sweep_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (leave_write) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      work_rd_en   = issue && ((state_ff == ST_SCAN) || save_ff);
      snap_rd_en   = issue && (state_ff == ST_COPY) && !save_ff;
      snap_wr_en   = (state_ff == ST_COPY) && ev_pend_ff && save_ff;
      work_wr_en   = (leave_write && have_ff) ||
                     ((state_ff == ST_COPY) && ev_pend_ff && !save_ff);
      work_wr_addr = (state_ff == ST_WRITE) ? best_idx_ff : ev_idx_ff;
      work_wr_data = (state_ff == ST_WRITE) ? upd : ent;
   end

   // entry evaluation and winner update
   always_comb begin
      ent = '0;
      if (rd_vld_ff) begin
         ent = ((state_ff == ST_COPY) && !save_ff) ? entry_type'(snap_rd_raw)
                                                   : entry_type'(work_rd_raw);
      end
      room      = ent.vend - t_ff;
      void_ok   = (t_ff >= ent.vstart) && (ent.vend >= t_ff) && (room >= dur_ff);
      hor_ok    = (t_ff >= ent.hor);
      gap_v     = t_ff - ent.vstart;
      gap_h     = t_ff - ent.hor;
      pick_void = void_ok && (!hor_ok || (gap_v <= gap_h));
      cand_ok   = void_ok || hor_ok;
      cand_gap  = pick_void ? gap_v : gap_h;
      take      = (state_ff == ST_SCAN) && ev_pend_ff && cand_ok &&
                  (!have_ff || (cand_gap < best_gap_ff));

      upd = best_ent_ff;
      if (t_ff >= best_ent_ff.hor) begin
         upd.vstart = best_ent_ff.hor;
         upd.hor    = sum_ff;
         upd.vend   = t_ff;
      end else begin
         upd.vstart = sum_ff;
      end

      sum_full = {1'b0, TIME_BITS'(req_request_time)} +
                 {1'b0, TIME_BITS'(req_duration)};
   end

   // register next values
   always_comb begin
      save_in      = save_ff;
      cnt_in       = cnt_ff;
      ev_pend_in   = issue;
      ev_idx_in    = rd_addr;
      rd_vld_in    = rd_vld_ff;
      t_in         = t_ff;
      dur_in       = dur_ff;
      sum_in       = sum_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_gap_in  = best_gap_ff;
      best_ent_in  = best_ent_ff;
      work_vld_in  = work_vld_ff;
      snap_vld_in  = snap_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_start_in   = rsp_start_ff;

      if (accept) begin
         save_in = (req_command == CMD_SAVE);
         cnt_in  = '0;
         t_in    = TIME_BITS'(req_request_time);
         dur_in  = TIME_BITS'(req_duration);
         sum_in  = sum_full[TIME_BITS] ? '1 : sum_full[TIME_BITS-1:0];
         have_in = 1'b0;
      end

      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
         if ((state_ff == ST_COPY) && !save_ff) begin
            rd_vld_in = snap_vld_ff[rd_addr];
         end else begin
            rd_vld_in = work_vld_ff[rd_addr];
         end
      end

      if (take) begin
         have_in     = 1'b1;
         best_idx_in = ev_idx_ff;
         best_gap_in = cand_gap;
         best_ent_in = ent;
      end

      if (snap_wr_en) begin
         snap_vld_in[ev_idx_ff] = 1'b1;
      end
      if (work_wr_en) begin
         work_vld_in[work_wr_addr] = 1'b1;
      end

      // free the result slot once taken, refill at the end of a schedule
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (leave_write) begin
         rsp_valid_in   = 1'b1;
         rsp_found_in   = have_ff;
         rsp_channel_in = have_ff ? CHANNEL_BITS'(best_idx_ff) : '0;
         rsp_start_in   = have_ff ? FIELD_TIME_BITS'(t_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ev_pend_ff   <= 1'b0;
         have_ff      <= 1'b0;
         work_vld_ff  <= '0;
         snap_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ev_pend_ff   <= ev_pend_in;
         have_ff      <= have_in;
         work_vld_ff  <= work_vld_in;
         snap_vld_ff  <= snap_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      save_ff        <= save_in;
      ev_idx_ff      <= ev_idx_in;
      rd_vld_ff      <= rd_vld_in;
      t_ff           <= t_in;
      dur_ff         <= dur_in;
      sum_ff         <= sum_in;
      best_idx_ff    <= best_idx_in;
      best_gap_ff    <= best_gap_in;
      best_ent_ff    <= best_ent_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_start_ff   <= rsp_start_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_start_time = rsp_start_ff;

endmodule

// ===== rtl/dlvfs_checker.sv =====
// Port-level checker for the scheduler top level, with its bind.
`include "delay_line_void_filling_scheduler_top_assert.svh"

module dlvfs_checker
   import dlvfs_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [1:0]                 req_command,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_found,
   input logic [CHANNEL_BITS-1:0]    rsp_channel,
   input logic [FIELD_TIME_BITS-1:0] rsp_start_time
);

   logic                                  rsp_held;
   logic                                  table_cmd;
   logic                                  table_acc;
   logic [CHANNEL_BITS+FIELD_TIME_BITS:0] rsp_payload;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign table_cmd   = req_command inside {CMD_SCHEDULE, CMD_SAVE, CMD_RESTORE};
   assign table_acc   = req_valid && !req_stall && table_cmd;
   assign rsp_payload = {rsp_found, rsp_channel, rsp_start_time};

   // a scheduled or copied item keeps the block busy on the next cycle
   `DLVFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, table_acc, req_stall)
   // a new result only appears at the end of a busy period
   `DLVFS_ASSERT_IMPLIES(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   `DLVFS_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_held, rsp_valid)
   `DLVFS_ASSERT_NEXT(a_rsp_payload_hold, clock, reset, rsp_held, $stable(rsp_payload))

endmodule

bind delay_line_void_filling_scheduler_top dlvfs_checker u_dlvfs_checker (.*);

// ===== tb/sv/delay_line_void_filling_scheduler_top_tb.sv =====
// Testbench for the delay line void filling scheduler: directed and random checks.
`timescale 1ns / 1ps

module delay_line_void_filling_scheduler_top_tb
   import dlvfs_pkg::*;
();

   localparam int NUM_CH        = NUM_CHANNELS_DEF;
   localparam int SETTLE_CYCLES = 2 * (NUM_CH + 3);
   localparam int MAX_CYCLES    = 600000;
   localparam int MAX_GAP       = 30;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [FIELD_TIME_BITS-1:0] TIME_MAX = '1;

   typedef logic [FIELD_TIME_BITS-1:0] tick_type;

   typedef struct {
      logic                    found;
      logic [CHANNEL_BITS-1:0] channel;
      tick_type                start_time;
   } grant_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_command = CMD_SCHEDULE;
   tick_type                   req_request_time = '0;
   tick_type                   req_duration = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_found;
   logic [CHANNEL_BITS-1:0]    rsp_channel;
   tick_type                   rsp_start_time;

   // Predicted channel table and its snapshot
   tick_type chan_horizon    [NUM_CH];
   tick_type chan_void_start [NUM_CH];
   tick_type chan_void_end   [NUM_CH];
   tick_type snap_horizon    [NUM_CH];
   tick_type snap_void_start [NUM_CH];
   tick_type snap_void_end   [NUM_CH];

   grant_type   expected_grants [$];
   grant_type   oldest_grant;
   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          hold_cycles = 0;
   tick_type    window_base = '0;

   delay_line_void_filling_scheduler_top #(
      .NUM_CHANNELS (NUM_CH),
      .TIME_BITS    (FIELD_TIME_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_request_time (req_request_time),
      .req_duration     (req_duration),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_channel      (rsp_channel),
      .rsp_start_time   (rsp_start_time)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic tick_type sat_sum(tick_type a, tick_type b);
      logic [FIELD_TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FIELD_TIME_BITS] ? TIME_MAX : s[FIELD_TIME_BITS-1:0];
   endfunction

   // Save and restore copy the table; a schedule picks the smallest-gap channel, updates it and queues the grant.
   function automatic void schedule_grant(logic [1:0] cmd, tick_type t, tick_type dur);
      bit        have;
      tick_type  best_gap;
      int        best;
      grant_type g;
      have = 1'b0;
      best_gap = '0;
      best = 0;
      if (cmd == CMD_SAVE) begin
         snap_horizon = chan_horizon;
         snap_void_start = chan_void_start;
         snap_void_end = chan_void_end;
      end else if (cmd == CMD_RESTORE) begin
         chan_horizon = snap_horizon;
         chan_void_start = snap_void_start;
         chan_void_end = snap_void_end;
      end else if (cmd == CMD_SCHEDULE) begin
         for (int i = 0; i < NUM_CH; i++) begin
            // void test first so it wins a tie within the channel
            if (t >= chan_void_start[i] && chan_void_end[i] >= t &&
                chan_void_end[i] - t >= dur) begin
               if (!have || t - chan_void_start[i] < best_gap) begin
                  have = 1'b1;
                  best_gap = t - chan_void_start[i];
                  best = i;
               end
            end
            if (t >= chan_horizon[i]) begin
               if (!have || t - chan_horizon[i] < best_gap) begin
                  have = 1'b1;
                  best_gap = t - chan_horizon[i];
                  best = i;
               end
            end
         end
         if (have) begin
            if (t >= chan_horizon[best]) begin
               chan_void_start[best] = chan_horizon[best];
               chan_horizon[best] = sat_sum(t, dur);
               chan_void_end[best] = t;
            end else begin
               chan_void_start[best] = sat_sum(t, dur);
            end
            g.found = 1'b1;
            g.channel = best[CHANNEL_BITS-1:0];
            g.start_time = t;
         end else begin
            g.found = 1'b0;
            g.channel = '0;
            g.start_time = '0;
         end
         expected_grants.push_back(g);
      end
   endfunction

   function automatic int pick_gap(int pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < pct)
         gap++;
      return gap;
   endfunction

   // Offer one item; returns at the rising edge that takes it.
   task automatic send_item(logic [1:0] cmd, tick_type t, tick_type dur);
      int gap;
      gap = pick_gap(req_idle_pct);
      @(negedge clock);
      repeat (gap) begin
         req_valid = 1'b0;
         req_command = 2'($urandom_range(3));
         req_request_time = $urandom;
         req_duration = $urandom;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_request_time = t;
      req_duration = dur;
      do
         @(posedge clock);
      while (req_stall);
      schedule_grant(cmd, t, dur);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_grants.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: honor a requested hold-off first, else stall at random.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grants.size() == 0) begin
            $error("result item with nothing expected: found %0d channel %0d start %0h",
                   rsp_found, rsp_channel, rsp_start_time);
            error_count++;
         end else begin
            oldest_grant = expected_grants.pop_front();
            if (rsp_found !== oldest_grant.found) begin
               $error("found: expected %0d, got %0d", oldest_grant.found, rsp_found);
               error_count++;
            end
            if (rsp_channel !== oldest_grant.channel) begin
               $error("channel: expected %0d, got %0d", oldest_grant.channel, rsp_channel);
               error_count++;
            end
            if (rsp_start_time !== oldest_grant.start_time) begin
               $error("start_time: expected %0h, got %0h",
                      oldest_grant.start_time, rsp_start_time);
               error_count++;
            end
         end
      end
   end

   // Zero duration, horizon grants, void fills, exact fit, void ending too early.
   task automatic test_void_fill();
      send_item(CMD_SCHEDULE, 32'd0, 32'd0);
      send_item(CMD_SCHEDULE, 32'd100, 32'd50);
      send_item(CMD_SCHEDULE, 32'd20, 32'd30);
      send_item(CMD_SCHEDULE, 32'd60, 32'd50);
      send_item(CMD_SCHEDULE, 32'd90, 32'd10);
      send_item(CMD_SCHEDULE, 32'd120, 32'd5);
   endtask

   task automatic test_snapshot();
      send_item(CMD_SAVE, 32'd0, 32'd1);
      send_item(CMD_SCHEDULE, 32'd200, 32'd10);
      send_item(CMD_SCHEDULE, 32'd200, 32'd10);
      send_item(CMD_RESTORE, 32'd0, 32'd1);
      send_item(CMD_SCHEDULE, 32'd200, 32'd10);
      send_item(CMD_UNUSED, 32'd200, 32'd10);
      send_item(CMD_SCHEDULE, 32'd200, 32'd10);
   endtask

   task automatic test_saturation();
      send_item(CMD_SCHEDULE, TIME_MAX - 32'd15, TIME_MAX);
      send_item(CMD_SCHEDULE, TIME_MAX, TIME_MAX);
      send_item(CMD_SCHEDULE, TIME_MAX, 32'd1);
      send_item(CMD_SCHEDULE, 32'd0, TIME_MAX);
   endtask

   // Push every horizon to the top, then ask for more than any void holds.
   task automatic test_no_fit();
      repeat (NUM_CH) send_item(CMD_SCHEDULE, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(CMD_SCHEDULE, 32'h8000_0000, 32'h8000_0000);
   endtask

   // Mostly requests in a drifting time window so voids form and get filled.
   task automatic test_random_traffic(int count);
      int       n;
      int       kind;
      tick_type t;
      tick_type dur;
      n = 0;
      while (n < count) begin
         kind = $urandom_range(99);
         if (kind < 4) begin
            send_item(CMD_SAVE, $urandom, $urandom);
            n++;
         end else if (kind < 8) begin
            send_item(CMD_RESTORE, $urandom, $urandom);
            n++;
         end else if (kind < 10) begin
            send_item(CMD_UNUSED, $urandom, $urandom);
         end else if (kind < 15) begin
            send_item(CMD_SCHEDULE, $urandom, $urandom >> $urandom_range(31));
            n++;
         end else begin
            if ($urandom_range(199) == 0)
               window_base = ($urandom_range(3) == 0) ? TIME_MAX - $urandom_range(3000)
                                                      : $urandom;
            if ($urandom_range(9) == 0)
               window_base = (window_base > 300) ? window_base - $urandom_range(300) : '0;
            else
               window_base = sat_sum(window_base, $urandom_range(60));
            t = sat_sum(window_base, $urandom_range(400));
            dur = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(1, 120);
            send_item(CMD_SCHEDULE, t, dur);
            n++;
         end
      end
   endtask

   // Hold the receiver off while items keep coming so the block backs up.
   task automatic test_backpressure();
      @(posedge clock);
      hold_cycles = 400;
      repeat (20)
         send_item(CMD_SCHEDULE, sat_sum(window_base, $urandom_range(400)),
                   $urandom_range(1, 120));
      wait (hold_cycles == 0);
   endtask

   initial begin
      for (int i = 0; i < NUM_CH; i++) begin
         chan_horizon[i] = '0;
         chan_void_start[i] = '0;
         chan_void_end[i] = '0;
         snap_horizon[i] = '0;
         snap_void_start[i] = '0;
         snap_void_end[i] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_void_fill();
      test_snapshot();
      test_saturation();
      test_no_fit();
      wait_drained();

      req_idle_pct = 18;
      rsp_idle_pct = 58;
      test_random_traffic(355);
      wait_drained();

      req_idle_pct = 58;
      rsp_idle_pct = 18;
      test_random_traffic(355);
      wait_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_backpressure();
      test_random_traffic(355);
      wait_drained();

      if (expected_grants.size() != 0) begin
         $error("%0d expected results never arrived", expected_grants.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
